### sv/assert_macros.svh
// Assertion macros shared by the circular queue RTL.
// Used by files that carry concurrent checks; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("circular queue check failed");

// Condition that must never hold at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("circular queue forbidden condition seen");

`endif

### sv/cqs_pkg.sv
// Package of the circular queue with search: item types, codes and fixed widths.
// Used by the controller, the storage cells and the top level; depends on nothing.
package cqs_pkg;

  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int POS_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_SRCH = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  // One input item.
  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] value;
  } cqs_cmd_t;

  // One result item.
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] out_value;
    logic [POS_W-1:0]         position;
  } cqs_result_t;

  // Control broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                     shift;
    logic                     load;
    logic signed [DATA_W-1:0] load_data;
  } cqs_chain_t;

endpackage

### sv/cqs_cell.sv
// One storage cell of the queue chain: holds the entry at a fixed distance from the oldest.
// Depends on cqs_pkg for the chain control struct.
module cqs_cell import cqs_pkg::*; #(
  parameter int IW     = 4,
  parameter int MY_IDX = 0
) (
  input  logic                     clk,
  input  cqs_chain_t               chain,
  input  logic [IW-1:0]            load_idx,
  input  logic signed [DATA_W-1:0] nbr_data,
  output logic signed [DATA_W-1:0] data
);

  localparam logic [IW-1:0] MY = IW'(MY_IDX);

  // A directed load wins over the shift toward the head of the chain.
  always_ff @(posedge clk) begin
    if (chain.load && (load_idx == MY)) begin
      data <= chain.load_data;
    end else if (chain.shift) begin
      data <= nbr_data;
    end
  end

endmodule

### sv/cqs_ctrl.sv
// Controller of the circular queue: fill count, capacity register, search sequencer, results.
// Depends on cqs_pkg and assert_macros.svh; drives the cell chain of the top level.
`include "assert_macros.svh"

module cqs_ctrl import cqs_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  cqs_cmd_t                 cmd,
  output logic                     busy,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_data,
  output logic                     done,
  output cqs_result_t              result,
  input  logic signed [DATA_W-1:0] head_data,
  output cqs_chain_t               chain,
  output logic [IW-1:0]            load_idx
);

  localparam int EW = (CW > POS_W) ? CW : POS_W;

  state_t                   state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [CAP_W-1:0]         cap;
  logic [CW-1:0]            cap_eff;
  logic [CW-1:0]            step;
  logic [CW-1:0]            cnt_m1;
  logic signed [DATA_W-1:0] key;
  logic                     found;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         pos_here;
  logic [EW-1:0]            cap_ext;
  logic [EW-1:0]            pos_ext;
  logic                     done_next;
  cqs_result_t              result_next;
  logic                     accept;
  logic                     cfg_wr;
  logic                     match;
  logic                     last;

  assign busy      = (state == S_SEARCH);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Capacity in use: zero acts as one, anything above the chain length acts as the length.
  assign cap_ext = EW'(cap);
  always_comb begin
    if (cap == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > EW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = cap_ext[CW-1:0];
    end
  end

  // Search bookkeeping: the head cell is compared once per rotation step.
  assign cnt_m1   = count - CW'(1);
  assign match    = (head_data == key);
  assign last     = (step == cnt_m1);
  assign pos_ext  = EW'(step) + EW'(1);
  assign pos_here = pos_ext[POS_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (cmd.opcode == OP_SRCH) && (count != '0)) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Chain control, fill count and result for the current cycle.
  always_comb begin
    chain       = '0;
    load_idx    = '0;
    count_next  = count;
    done_next   = 1'b0;
    result_next = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.opcode)
            OP_ENQ: begin
              done_next = 1'b1;
              if (count == cap_eff) begin
                result_next.status = ST_FULL;
              end else begin
                chain.load      = 1'b1;
                chain.load_data = cmd.value;
                load_idx        = count[IW-1:0];
                count_next      = count + CW'(1);
              end
            end
            OP_DEQ: begin
              done_next = 1'b1;
              if (count == '0) begin
                result_next.status = ST_EMPTY;
              end else begin
                chain.shift           = 1'b1;
                result_next.out_value = head_data;
                count_next            = cnt_m1;
              end
            end
            OP_SRCH: begin
              if (count == '0) begin
                done_next          = 1'b1;
                result_next.status = ST_EMPTY;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        // Rotate the occupied part of the chain by one; the head goes to the newest place.
        chain.shift     = 1'b1;
        chain.load      = 1'b1;
        chain.load_data = head_data;
        load_idx        = cnt_m1[IW-1:0];
        if (last) begin
          done_next = 1'b1;
          if (found) begin
            result_next.position = pos;
          end else if (match) begin
            result_next.position = pos_here;
          end else begin
            result_next.status = ST_NOTFOUND;
          end
        end
      end
      default: begin
        chain = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cap   <= CAP_RESET;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (accept) begin
        found <= 1'b0;
      end else if (busy && match) begin
        found <= 1'b1;
      end
      // A capacity write empties the queue.
      if (cfg_wr) begin
        cap   <= cfg_data;
        count <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    result <= result_next;
    if (accept) begin
      key  <= cmd.value;
      step <= '0;
    end else if (busy) begin
      step <= step + CW'(1);
      if (match && !found) begin
        pos <= pos_here;
      end
    end
  end

  `ASSERT_NEVER(a_count_in_cap, clk, rst, count > cap_eff)
  `ASSERT_PROP(a_done_has_cause, clk, rst, done |-> ($past(start && !busy) || $past(busy)))
  `ASSERT_NEVER(a_search_nonempty, clk, rst, busy && (count == '0))
  `ASSERT_PROP(a_search_ends, clk, rst, (busy && last) |=> (!busy && done))

endmodule

### sv/circular_queue_with_search.sv
// Circular queue of signed 32-bit words with search, built as a chain of storage cells.
// Command channel: an item (opcode, value) is taken at a rising edge with start high and
// busy low. Opcodes: enqueue, dequeue, search; the unused code answers ok and changes nothing.
// Result channel: every item gives one result (status, out_value, position), shown for one
// cycle with done high. The receiver cannot stall, so a result is never held back.
// Enqueue, dequeue and the unused code answer in the cycle after they are taken, and a new item
// can be taken in every cycle while busy is low. A search on an empty queue answers the same way.
// Any other search rotates the occupied cells once through the head cell, one step a cycle,
// holding busy high until the last step, and answers in the cycle after that step; it covers
// every entry held (1 to DEPTH). The rotation restores the original order.
// Configuration: cfg_data writes the capacity at an edge with cfg_valid and cfg_ready high;
// cfg_ready is low during a search. A write empties the queue. Capacity zero acts as one,
// values above DEPTH act as DEPTH.
// Reset (rst, synchronous) empties the queue and sets the capacity to 16. Cell contents are
// not cleared; only occupied cells are ever read.
module circular_queue_with_search import cqs_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cqs_cmd_t         cmd,
  output logic             busy,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output logic             done,
  output cqs_result_t      result
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cqs_chain_t               chain;
  logic [IW-1:0]            load_idx;
  logic signed [DATA_W-1:0] data_q [DEPTH];

  // Sequencer, fill count and capacity register.
  cqs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result),
    .head_data (data_q[0]),
    .chain     (chain),
    .load_idx  (load_idx)
  );

  // Cell i holds the entry i places behind the oldest; shifts move data toward cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_mid
      cqs_cell #(
        .IW     (IW),
        .MY_IDX (i)
      ) u_cell (
        .clk      (clk),
        .chain    (chain),
        .load_idx (load_idx),
        .nbr_data (data_q[i+1]),
        .data     (data_q[i])
      );
    end else begin : g_end
      cqs_cell #(
        .IW     (IW),
        .MY_IDX (i)
      ) u_cell (
        .clk      (clk),
        .chain    (chain),
        .load_idx (load_idx),
        .nbr_data (data_q[i]),
        .data     (data_q[i])
      );
    end
  end

endmodule

### bench/tb_circular_queue_with_search.sv
`timescale 1ns / 100ps
// Testbench of circular_queue_with_search: a directed and a random command stream checked
// against a shadow queue kept in the bench. Depends on cqs_pkg and the top-level RTL only.
module tb_circular_queue_with_search;
  import cqs_pkg::*;

  localparam int QDEPTH = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  cqs_cmd_t cmd = '0;
  logic busy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;
  logic done;
  cqs_result_t result;

  // Shadow copy of the queue contents and pointers.
  logic signed [DATA_W-1:0] shadow_slot [QDEPTH];
  int shadow_head = 0;
  int shadow_tail = 0;
  logic shadow_empty = 1'b1;
  logic [CAP_W-1:0] shadow_cap = CAP_RESET;

  cqs_cmd_t cmd_backlog [$];
  cqs_result_t answer_fifo [$];
  logic signed [DATA_W-1:0] recent_values [$];
  int queued_count = 0;
  int accepted_count = 0;
  int mismatches = 0;
  int sender_idle_pct = 33;

  circular_queue_with_search #(.DEPTH(QDEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Capacity in force: zero acts as one, anything above the depth acts as the depth.
  function automatic int live_capacity();
    if (shadow_cap == 0) return 1;
    if (shadow_cap > QDEPTH) return QDEPTH;
    return int'(shadow_cap);
  endfunction

  function automatic int wrap_next(input int idx);
    return (idx + 1 >= live_capacity()) ? 0 : idx + 1;
  endfunction

  // Applies one command to the shadow queue and returns the answer it must produce.
  function automatic cqs_result_t apply_command(input cqs_cmd_t c);
    cqs_result_t r;
    int cur;
    int n;
    r = '0;
    r.status = ST_OK;
    case (c.opcode)
      OP_ENQ: begin
        if (shadow_empty) begin
          shadow_head = 0;
          shadow_tail = 0;
          shadow_slot[0] = c.value;
          shadow_empty = 1'b0;
        end else if (wrap_next(shadow_tail) == shadow_head) begin
          r.status = ST_FULL;
        end else begin
          shadow_tail = wrap_next(shadow_tail);
          shadow_slot[shadow_tail] = c.value;
        end
      end
      OP_DEQ: begin
        if (shadow_empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = shadow_slot[shadow_head];
          if (shadow_head == shadow_tail) begin
            shadow_head = 0;
            shadow_tail = 0;
            shadow_empty = 1'b1;
          end else begin
            shadow_head = wrap_next(shadow_head);
          end
        end
      end
      OP_SRCH: begin
        if (shadow_empty) begin
          r.status = ST_EMPTY;
        end else begin
          // Scan from the oldest entry; the first match gives the position.
          r.status = ST_NOTFOUND;
          cur = shadow_head;
          for (n = 1; n <= live_capacity(); n++) begin
            if (shadow_slot[cur] == c.value) begin
              r.status = ST_OK;
              r.position = POS_W'(n);
              break;
            end
            if (cur == shadow_tail) break;
            cur = wrap_next(cur);
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Driver: records each accepted item and presents the next one from the backlog.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        answer_fifo.push_back(apply_command(cmd));
        accepted_count++;
      end
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          start <= 1'b1;
          cmd <= cmd_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest predicted answer.
  always @(posedge clk) begin
    cqs_result_t want;
    if (!rst && done) begin
      if (answer_fifo.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result status=%0d out_value=%0d position=%0d",
                 $realtime, result.status, result.out_value, result.position);
      end else begin
        want = answer_fifo.pop_front();
        if (result.status !== want.status || result.out_value !== want.out_value ||
            result.position !== want.position) begin
          mismatches++;
          $display(
            "%0t: mismatch expected status=%0d out_value=%0d position=%0d, got %0d %0d %0d",
            $realtime, want.status, want.out_value, want.position,
            result.status, result.out_value, result.position);
        end
      end
    end
  end

  task automatic queue_item(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
    cqs_cmd_t c;
    c.opcode = op;
    c.value = val;
    cmd_backlog.push_back(c);
    queued_count++;
    if (op == OP_ENQ) begin
      recent_values.push_back(val);
      if (recent_values.size() > 32) void'(recent_values.pop_front());
    end
  endtask

  // Mix of extremes, small values that repeat often, and full-range words.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9, 0))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -1;
      4, 5: return $urandom_range(7, 0);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_key();
    if (recent_values.size() != 0 && $urandom_range(9, 0) < 7)
      return recent_values[$urandom_range(recent_values.size() - 1, 0)];
    return pick_value();
  endfunction

  // A run of random commands weighted toward enqueue or dequeue as asked.
  task automatic queue_batch(input int count, input int enq_pct, input int deq_pct);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      if (pick < enq_pct) queue_item(OP_ENQ, pick_value());
      else if (pick < enq_pct + deq_pct) queue_item(OP_DEQ, $urandom);
      else if (pick < 97) queue_item(OP_SRCH, pick_key());
      else queue_item(OP_UNUSED, $urandom);
    end
  endtask

  // Returns at a rising edge once every item is taken and every answer has arrived.
  task automatic wait_until_idle();
    do @(posedge clk);
    while (accepted_count != queued_count || answer_fifo.size() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_data <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    // The write empties the queue.
    shadow_cap = cap;
    shadow_head = 0;
    shadow_tail = 0;
    shadow_empty = 1'b1;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_setting(input logic [CAP_W-1:0] cap);
    wait_until_idle();
    write_capacity(cap);
    repeat (2) begin
      queue_batch(24, 70, 12);
      queue_batch(12, 15, 65);
    end
  endtask

  // Cycle limit for a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset capacity: empty cases, extremes, hits, a miss and the unused code.
    queue_item(OP_DEQ, '0);
    queue_item(OP_SRCH, 5);
    queue_item(OP_UNUSED, '0);
    queue_item(OP_ENQ, VAL_MAX);
    queue_item(OP_ENQ, VAL_MIN);
    queue_item(OP_ENQ, '0);
    queue_item(OP_ENQ, -1);
    queue_item(OP_SRCH, -1);
    queue_item(OP_SRCH, VAL_MAX);
    queue_item(OP_SRCH, 77);
    queue_item(OP_UNUSED, -1);
    queue_item(OP_DEQ, '0);
    queue_item(OP_SRCH, '0);
    queue_item(OP_DEQ, '0);
    queue_item(OP_DEQ, '0);
    queue_item(OP_DEQ, '0);
    queue_item(OP_DEQ, '0);

    // Single slot: full on the second enqueue, then empty again.
    wait_until_idle();
    write_capacity(5'd1);
    queue_item(OP_ENQ, 42);
    queue_item(OP_ENQ, 43);
    queue_item(OP_SRCH, 42);
    queue_item(OP_SRCH, 43);
    queue_item(OP_DEQ, '0);
    queue_item(OP_DEQ, '0);
    queue_item(OP_ENQ, 43);

    // Random part under several capacities and sender gap rates.
    sender_idle_pct = 33;
    run_setting(5'd16);
    run_setting(5'd3);
    run_setting(5'd0);
    wait_until_idle();
    sender_idle_pct = 67;
    run_setting(5'd31);
    run_setting(5'd1);
    run_setting(5'd9);
    wait_until_idle();
    sender_idle_pct = 0;
    run_setting(5'd16);
    run_setting(5'd2);
    run_setting(5'd17);
    run_setting(5'd7);

    wait_until_idle();
    repeat (QDEPTH + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
